// File: src/lslf_pkg.sv
// ----------------------------------------------------------------------------
// lslf_pkg
// Shared command and status types, status codes and the divider saturation
// helper for the least-squares line fit block.
// ----------------------------------------------------------------------------
package lslf_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DEGEN   = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    // Quotient bits produced per division: 32 result bits plus overflow bit
    localparam int DIV_STEPS = 33;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_ACCUM,
        OP_MUL_NUM,
        OP_MUL_DEN,
        OP_SUB_DEN,
        OP_START_B1,
        OP_LOAD_B1,
        OP_MUL_B0,
        OP_SUB_B0,
        OP_START_B0,
        OP_LOAD_B0,
        OP_READ,
        OP_MUL_P,
        OP_ADD_P,
        OP_NEXT,
        OP_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
        logic   out_degen;
    } dp_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic div_busy;
        logic rep_last;
    } dp_status_t;

    // Apply sign to a 33-bit magnitude quotient and saturate to 32 bits.
    // Bit 32 set means the magnitude reached 2^32.
    function automatic logic signed [31:0] div_sat(input logic [32:0] q, input logic neg);
        logic [31:0] m;
        m = q[31:0];
        if (q[32])
            return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        if (!neg)
            return q[31] ? 32'sh7fff_ffff : signed'(m);
        if (m > 32'h8000_0000)
            return 32'sh8000_0000;
        return signed'(32'(-m));
    endfunction

endpackage

// File: src/lslf_ram.sv
// ----------------------------------------------------------------------------
// lslf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lslf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/lslf_dp.sv
// ----------------------------------------------------------------------------
// lslf_dp
// Datapath: running sums, sample store, shared restoring divider, slope,
// intercept and prediction arithmetic, and the result register.
// ----------------------------------------------------------------------------
module lslf_dp import lslf_pkg::*; #(
    parameter int MAX_POINTS  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        x_value,
    input  logic [15:0]        y_value,
    input  dp_cmd_t            cmd,
    output dp_status_t         flags,
    output logic signed [31:0] slope,
    output logic signed [31:0] intercept,
    output logic signed [31:0] predicted_y,
    output logic [5:0]         point_index,
    output logic               last_result,
    output logic [1:0]         status
);

    localparam int S   = SAMPLE_BITS;
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int IW  = $clog2(MAX_POINTS);
    localparam int SXW = S + CW;
    localparam int SQW = 2 * S + CW;
    localparam int NW  = 2 * S + 2 * CW + 2;
    localparam int DW  = NW + 32;
    localparam int AW  = SXW + 33;
    localparam int MW  = 32 + S;
    localparam int PW  = S + 25;

    // Sample extraction: low S bits of each zero-padded field, taken as signed
    logic [S+15:0]         x_ext, y_ext;
    logic signed [S-1:0]   x_s, y_s;
    logic signed [2*S-1:0] xx, xy;

    assign x_ext = {{S{1'b0}}, x_value};
    assign y_ext = {{S{1'b0}}, y_value};
    assign x_s   = signed'(x_ext[S-1:0]);
    assign y_s   = signed'(y_ext[S-1:0]);
    assign xx    = x_s * x_s;
    assign xy    = x_s * y_s;

    // Run state
    logic [CW-1:0]         count_reg;
    logic signed [SXW-1:0] sum_x_reg, sum_y_reg;
    logic signed [SQW-1:0] sum_xx_reg, sum_xy_reg;
    logic                  dropped_reg;
    logic [IW-1:0]         rep_reg;
    logic [5:0]            cnt_reg;

    // Arithmetic payload
    logic signed [NW-1:0]  p1_reg, p2_reg, num_reg, den_reg;
    logic [DW-1:0]         r_reg, d_reg;
    logic [32:0]           q_reg;
    logic                  neg_reg;
    logic signed [31:0]    b1_reg, b0_reg, pred_reg;
    logic signed [AW-1:0]  prod_reg, a_reg;
    logic signed [MW-1:0]  pmul_reg;

    logic                  full;
    logic                  ge;
    logic [NW-1:0]         abs_num, abs_den;
    logic [AW-1:0]         abs_a;
    logic signed [CW:0]    n_s;
    logic [S-1:0]          x_rd;
    logic [MW-1:0]         pbias;
    logic signed [MW-1:0]  pround, ptr;
    logic signed [PW-1:0]  psum;
    logic                  pfits;
    logic signed [31:0]    psat;

    assign full    = (count_reg == CW'(MAX_POINTS));
    assign ge      = (r_reg >= d_reg);
    assign abs_num = num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
    assign abs_den = den_reg[NW-1] ? NW'(-den_reg) : NW'(den_reg);
    assign abs_a   = a_reg[AW-1] ? AW'(-a_reg) : AW'(a_reg);
    assign n_s     = signed'({1'b0, count_reg});

    // Prediction: b0 + trunc(b1*x / 256), saturated
    assign pbias  = {{(MW-8){1'b0}}, {8{pmul_reg[MW-1]}}};
    assign pround = pmul_reg + signed'(pbias);
    assign ptr    = pround >>> 8;
    assign psum   = PW'(ptr) + PW'(b0_reg);
    assign pfits  = (&psum[PW-1:31]) | ~(|psum[PW-1:31]);
    assign psat   = pfits ? psum[31:0] : (psum[PW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);

    assign flags.den_zero = (den_reg == '0);
    assign flags.div_busy = (cnt_reg != '0);
    assign flags.rep_last = ((CW'(rep_reg) + CW'(1)) == count_reg);

    lslf_ram #(
        .WIDTH (S),
        .DEPTH (MAX_POINTS)
    ) u_x_store (
        .clk   (clk),
        .we    ((cmd.op == OP_ACCUM) && !full),
        .waddr (count_reg[IW-1:0]),
        .wdata (x_s),
        .re    (cmd.op == OP_READ),
        .raddr (rep_reg),
        .rdata (x_rd)
    );

    // Sums, count, replay index and divider step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            sum_xx_reg  <= '0;
            sum_xy_reg  <= '0;
            dropped_reg <= 1'b0;
            rep_reg     <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            case (cmd.op) inside
                OP_ACCUM:
                begin
                    if (!full)
                    begin
                        count_reg  <= count_reg + CW'(1);
                        sum_x_reg  <= sum_x_reg + SXW'(x_s);
                        sum_y_reg  <= sum_y_reg + SXW'(y_s);
                        sum_xx_reg <= sum_xx_reg + SQW'(xx);
                        sum_xy_reg <= sum_xy_reg + SQW'(xy);
                    end
                    else
                    begin
                        dropped_reg <= 1'b1;
                    end
                end
                OP_START_B0: rep_reg <= '0;
                OP_NEXT:     rep_reg <= rep_reg + IW'(1);
                OP_CLEAR:
                begin
                    count_reg   <= '0;
                    sum_x_reg   <= '0;
                    sum_y_reg   <= '0;
                    sum_xx_reg  <= '0;
                    sum_xy_reg  <= '0;
                    dropped_reg <= 1'b0;
                end
                default: ;
            endcase

            case (cmd.op) inside
                OP_START_B1, OP_START_B0: cnt_reg <= 6'(DIV_STEPS);
                default:
                begin
                    if (cnt_reg != '0)
                    begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
            endcase
        end
    end

    // Arithmetic and result payload
    always_ff @(posedge clk)
    begin
        case (cmd.op) inside
            OP_MUL_NUM:
            begin
                p1_reg <= NW'(n_s * sum_xy_reg);
                p2_reg <= NW'(sum_x_reg * sum_y_reg);
            end
            OP_MUL_DEN:
            begin
                num_reg <= p1_reg - p2_reg;
                p1_reg  <= NW'(n_s * sum_xx_reg);
                p2_reg  <= NW'(sum_x_reg * sum_x_reg);
            end
            OP_SUB_DEN:  den_reg <= p1_reg - p2_reg;
            OP_START_B1:
            begin
                r_reg   <= DW'(abs_num) << 16;
                d_reg   <= DW'(abs_den) << 32;
                neg_reg <= num_reg[NW-1] ^ den_reg[NW-1];
            end
            OP_LOAD_B1:  b1_reg <= div_sat(q_reg, neg_reg);
            OP_MUL_B0:   prod_reg <= AW'(b1_reg * sum_x_reg);
            OP_SUB_B0:   a_reg <= (AW'(sum_y_reg) <<< 16) - prod_reg;
            OP_START_B0:
            begin
                r_reg   <= DW'(abs_a >> 8);
                d_reg   <= DW'(count_reg) << 32;
                neg_reg <= a_reg[AW-1];
            end
            OP_LOAD_B0:  b0_reg <= div_sat(q_reg, neg_reg);
            OP_MUL_P:    pmul_reg <= b1_reg * signed'(x_rd);
            OP_ADD_P:    pred_reg <= psat;
            default: ;
        endcase

        // Restoring divider: one quotient bit per cycle
        if (cnt_reg != '0)
        begin
            if (ge)
            begin
                r_reg <= r_reg - d_reg;
            end
            q_reg <= {q_reg[31:0], ge};
            d_reg <= d_reg >> 1;
        end

        if (cmd.out_load)
        begin
            if (cmd.out_degen)
            begin
                slope       <= '0;
                intercept   <= '0;
                predicted_y <= '0;
                point_index <= '0;
                last_result <= 1'b1;
                status      <= ST_DEGEN;
            end
            else
            begin
                slope       <= b1_reg;
                intercept   <= b0_reg;
                predicted_y <= pred_reg;
                point_index <= 6'(rep_reg);
                last_result <= flags.rep_last;
                status      <= dropped_reg ? ST_DROPPED : ST_OK;
            end
        end
    end

endmodule

// File: src/lslf_ctrl.sv
// ----------------------------------------------------------------------------
// lslf_ctrl
// Sequencer: collects points, steps the fit arithmetic, replays predictions
// and owns both channel handshakes.
// ----------------------------------------------------------------------------
module lslf_ctrl import lslf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_last,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t flags,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        COLLECT,
        MUL_NUM,
        MUL_DEN,
        SUB_DEN,
        CHECK,
        DIV_B1,
        LOAD_B1,
        MUL_B0,
        SUB_B0,
        START_B0,
        DIV_B0,
        LOAD_B0,
        READ,
        MUL_P,
        ADD_P,
        EMIT,
        DEGEN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   free;

    assign free      = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == COLLECT);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd.op        = OP_IDLE;
        cmd.out_load  = 1'b0;
        cmd.out_degen = 1'b0;
        unique case (state_reg)
            COLLECT:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_ACCUM;
                    if (in_last)
                    begin
                        state_next = MUL_NUM;
                    end
                end
            end
            MUL_NUM:
            begin
                cmd.op     = OP_MUL_NUM;
                state_next = MUL_DEN;
            end
            MUL_DEN:
            begin
                cmd.op     = OP_MUL_DEN;
                state_next = SUB_DEN;
            end
            SUB_DEN:
            begin
                cmd.op     = OP_SUB_DEN;
                state_next = CHECK;
            end
            CHECK:
            begin
                if (flags.den_zero)
                begin
                    state_next = DEGEN;
                end
                else
                begin
                    cmd.op     = OP_START_B1;
                    state_next = DIV_B1;
                end
            end
            DIV_B1:
            begin
                if (!flags.div_busy)
                begin
                    state_next = LOAD_B1;
                end
            end
            LOAD_B1:
            begin
                cmd.op     = OP_LOAD_B1;
                state_next = MUL_B0;
            end
            MUL_B0:
            begin
                cmd.op     = OP_MUL_B0;
                state_next = SUB_B0;
            end
            SUB_B0:
            begin
                cmd.op     = OP_SUB_B0;
                state_next = START_B0;
            end
            START_B0:
            begin
                cmd.op     = OP_START_B0;
                state_next = DIV_B0;
            end
            DIV_B0:
            begin
                if (!flags.div_busy)
                begin
                    state_next = LOAD_B0;
                end
            end
            LOAD_B0:
            begin
                cmd.op     = OP_LOAD_B0;
                state_next = READ;
            end
            READ:
            begin
                cmd.op     = OP_READ;
                state_next = MUL_P;
            end
            MUL_P:
            begin
                cmd.op     = OP_MUL_P;
                state_next = ADD_P;
            end
            ADD_P:
            begin
                cmd.op     = OP_ADD_P;
                state_next = EMIT;
            end
            EMIT:
            begin
                if (free)
                begin
                    cmd.out_load = 1'b1;
                    if (flags.rep_last)
                    begin
                        cmd.op     = OP_CLEAR;
                        state_next = COLLECT;
                    end
                    else
                    begin
                        cmd.op     = OP_NEXT;
                        state_next = READ;
                    end
                end
            end
            DEGEN:
            begin
                if (free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_degen = 1'b1;
                    cmd.op        = OP_CLEAR;
                    state_next    = COLLECT;
                end
            end
            default:
            begin
                state_next = COLLECT;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= COLLECT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while stalled");

    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        flags.div_busy |-> (state_reg == DIV_B1 || state_reg == DIV_B0))
        else $error("divider running outside a divide state");

    a_degen_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DEGEN && cmd.out_load) |=> (out_valid_reg && state_reg == COLLECT))
        else $error("degenerate result not presented");
`endif

endmodule

// File: src/least_squares_line_fit_core.sv
// ----------------------------------------------------------------------------
// least_squares_line_fit_core
// Straight-line least-squares fit over a stream of Q8.8 points, with one
// Q16.16 prediction returned per stored point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries x_value, y_value, last_point.
//   Points are taken one per cycle while the block is collecting. Each is
//   stored and summed; beyond MAX_POINTS a point is dropped and the run is
//   flagged. The transaction with last_point set starts the fit.
//   The fit forms the products and checks for a zero denominator, runs the
//   slope division, forms the intercept numerator, runs the intercept
//   division and loads the intercept, on one shared bit-per-cycle
//   restoring divider.
//   Each prediction then passes in turn through the store read, the
//   multiply, the add-and-saturate and the result load. A degenerate set
//   gives one transaction with status 1 instead.
//   Output channel (out_valid/out_ready) holds each result in a register;
//   a stalled receiver holds the replay, and the next data set may start
//   while the final result still waits. At reset sums, count and flags
//   clear at once; the sample store needs no clearing pass.
// ----------------------------------------------------------------------------
module least_squares_line_fit_core import lslf_pkg::*; #(
    parameter int MAX_POINTS  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] x_value,
    input  logic signed [15:0] y_value,
    input  logic               last_point,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] slope,
    output logic signed [31:0] intercept,
    output logic signed [31:0] predicted_y,
    output logic [5:0]         point_index,
    output logic               last_result,
    output logic [1:0]         status
);

    // Command and status between sequencer and datapath
    dp_cmd_t    cmd;
    dp_status_t flags;

    // Sequencer: drives both handshakes and steps the datapath
    lslf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (last_point),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .flags     (flags),
        .cmd       (cmd)
    );

    // Datapath: sums, store, divider and the result register
    lslf_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .x_value     (x_value),
        .y_value     (y_value),
        .cmd         (cmd),
        .flags       (flags),
        .slope       (slope),
        .intercept   (intercept),
        .predicted_y (predicted_y),
        .point_index (point_index),
        .last_result (last_result),
        .status      (status)
    );

endmodule

// File: verif/line_fit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_fit_checker
// Watches both channels of the line fit core, predicts each fit result from
// the accepted points and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module line_fit_checker import lslf_pkg::*; #(
    parameter int MAX_POINTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] x_value,
    input  logic signed [15:0] y_value,
    input  logic               last_point,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] slope,
    input  logic signed [31:0] intercept,
    input  logic signed [31:0] predicted_y,
    input  logic [5:0]         point_index,
    input  logic               last_result,
    input  logic [1:0]         status,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic signed [31:0] b1;
        logic signed [31:0] b0;
        logic signed [31:0] pred;
        logic [5:0]         idx;
        logic               fin;
        logic [1:0]         st;
    } fit_result_t;

    fit_result_t fit_queue[$];

    longint xs[MAX_POINTS];
    int     npts;
    longint sx, sy, sxx, sxy;
    bit     dropped;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)  return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Slope quotient: truncate toward zero, scale by 2^16, saturate.
    function automatic longint slope_q16(input longint num, input longint den);
        longint unsigned an, ad, q, r;
        bit neg;
        an  = num < 0 ? -num : num;
        ad  = den < 0 ? -den : den;
        neg = (num < 0) != (den < 0);
        q = an / ad;
        r = an % ad;
        if (q >= 64'd65536)
            return neg ? -64'sd2147483648 : 64'sd2147483647;
        for (int i = 0; i < 16; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= ad)
            begin
                r = r - ad;
                q = q | 1;
            end
        end
        return clamp32(neg ? -longint'(q) : longint'(q));
    endfunction

    task automatic add_point(input longint x, input longint y, input bit fin);
        longint n, num, den, b1, b0;
        fit_result_t r;
        if (npts < MAX_POINTS)
        begin
            xs[npts] = x;
            npts++;
            sx += x;
            sy += y;
            sxx += x * x;
            sxy += x * y;
        end
        else
            dropped = 1;
        if (!fin)
            return;
        n   = npts;
        num = n * sxy - sx * sy;
        den = n * sxx - sx * sx;
        if (den == 0 || n == 0)
        begin
            r = '{0, 0, 0, 0, 1'b1, ST_DEGEN};
            fit_queue = {fit_queue, r};
        end
        else
        begin
            b1 = slope_q16(num, den);
            b0 = clamp32((sy * 65536 - b1 * sx) / (256 * n));
            for (int i = 0; i < npts; i++)
            begin
                r.b1   = b1[31:0];
                r.b0   = b0[31:0];
                r.pred = 32'(clamp32(b0 + (b1 * xs[i]) / 256));
                r.idx  = i[5:0];
                r.fin  = (i + 1 == npts);
                r.st   = dropped ? ST_DROPPED : ST_OK;
                fit_queue = {fit_queue, r};
            end
        end
        npts = 0;
        sx = 0; sy = 0; sxx = 0; sxy = 0;
        dropped = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fit_result_t e;
        if (!rst_n)
        begin
            fit_queue.delete();
            npts = 0;
            sx = 0; sy = 0; sxx = 0; sxy = 0;
            dropped = 0;
            fail_count <= 0;
        end
        else
        begin
            // compare before predicting: a result cannot stem from this edge's point
            if (out_valid && out_ready)
            begin
                if (fit_queue.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual idx %0d",
                             $time, point_index);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = fit_queue.pop_front();
                    if (e != {slope, intercept, predicted_y, point_index,
                              last_result, status})
                    begin
                        $display("%0t: mismatch expected b1 %0d b0 %0d p %0d i %0d l %0d s %0d",
                                 $time, e.b1, e.b0, e.pred, e.idx, e.fin, e.st);
                        $display("%0t:          actual b1 %0d b0 %0d p %0d i %0d l %0d s %0d",
                                 $time, slope, intercept, predicted_y, point_index,
                                 last_result, status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                add_point(x_value, y_value, last_point);
        end
        pending = fit_queue.size();
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives point sets into the line fit core with random gaps and receiver
// stalls; the checker predicts and compares, this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int  MAXP      = 64;
    localparam longint LIMIT  = 2000000;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [15:0] x_value = 0;
    logic signed [15:0] y_value = 0;
    logic last_point = 0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [31:0] slope, intercept, predicted_y;
    logic [5:0] point_index;
    logic last_result;
    logic [1:0] status;
    int fail_count, pending;
    longint cycles = 0;
    bit hold_rx = 0;      // long receiver hold-off in progress

    always #5 clk = ~clk;

    least_squares_line_fit_core #(.MAX_POINTS(MAXP), .SAMPLE_BITS(16)) DUT (.*);

    line_fit_checker #(.MAX_POINTS(MAXP)) u_checker (.*);

    // Drive one point transaction; hold it until accepted.
    task automatic send_point(input logic [15:0] x, input logic [15:0] y, input bit fin,
                              input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 16) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1;
        x_value    <= x;
        y_value    <= y;
        last_point <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Send a data set of n points; style picks the value pattern.
    task automatic send_set(input int n, input int style, input bit gaps);
        logic [15:0] x, y;
        int base, step;
        base = $urandom_range(0, 65535);
        step = $urandom_range(1, 600) - 300;
        for (int i = 0; i < n; i++)
        begin
            case (style)
                0: begin x = 16'($urandom); y = 16'($urandom); end
                1: begin x = 16'(base + i * step); y = 16'(x * 3 + $urandom_range(0, 255)); end
                2: begin x = 16'(base); y = 16'($urandom); end     // constant x: degenerate
                default: begin
                    x = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                    y = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                end
            endcase
            send_point(x, y, i == n - 1, gaps);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    // Receiver: random stalls, or a long hold-off when asked.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rx)
                out_ready <= 0;
            else
            begin
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
                if (gap != 0)
                begin
                    out_ready <= 0;
                    repeat (gap - 1) @(negedge clk);
                    @(negedge clk);
                end
                out_ready <= 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int sent;
        repeat (7) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: extremes, single point, constant x, exact line, overflow
        send_point(16'h7fff, 16'h8000, 1, 0);          // single point degenerate
        send_point(16'h8000, 16'h7fff, 0, 0);
        send_point(16'h7fff, 16'h8000, 1, 0);
        send_point(16'h0000, 16'h0000, 0, 0);
        send_point(16'h0100, 16'h0200, 0, 0);
        send_point(16'h0200, 16'h0400, 1, 0);
        send_set(3, 2, 0);
        send_set(4, 3, 0);
        wait_drained();
        send_set(MAXP + 3, 0, 0);                      // capacity overflow, status 2
        wait_drained();

        // long hold-off so the block fills up and stalls its input
        hold_rx = 1;
        fork
            begin
                repeat (600) @(negedge clk);
                hold_rx = 0;
            end
            begin
                send_set(20, 1, 0);
                send_set(20, 0, 0);
            end
        join
        wait_drained();

        sent = 0;
        while (sent < 240)
        begin
            int n, style;
            n = $urandom_range(0, 9) == 0 ? $urandom_range(MAXP - 2, MAXP + 4)
                                          : $urandom_range(1, 8);
            style = $urandom_range(0, 9) < 6 ? $urandom_range(0, 1) : $urandom_range(2, 3);
            send_set(n, style, $urandom_range(0, 3) != 0);
            sent += n;
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
        wait_drained();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
src/lslf_pkg.sv
src/lslf_ram.sv
src/lslf_dp.sv
src/lslf_ctrl.sv
src/least_squares_line_fit_core.sv
verif/line_fit_checker.sv
verif/testbench.sv
